// ===== rtl/tget_pkg.sv =====
package tget_pkg;

   localparam int KEY_W   = 22;
   localparam int GROUP_W = 22;
   localparam int CMD_W   = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_CLEAR  = 3'd2,
      CMD_LOOKUP = 3'd3,
      CMD_QUERY  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_EMPTY   = 2'd0,
      ST_LIVE    = 2'd1,
      ST_RETIRED = 2'd2
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [KEY_W-1:0]   entry_key;
      logic [GROUP_W-1:0] group_tag;
      logic               pinned;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [GROUP_W-1:0] group_out;
      logic               none_live;
      logic               table_full;
   } rsp_type;

   // transaction travelling down the chain with its running result
   typedef struct packed {
      logic               valid;
      req_type            req;
      logic               hit;
      logic [GROUP_W-1:0] group_out;
      logic               live_seen;
   } token_type;

endpackage

// ===== rtl/tget_cell.sv =====
module tget_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  tget_pkg::token_type  token_i,
   output tget_pkg::token_type  token_o
);

   tget_pkg::status_type           status_ff, status_in;
   logic [tget_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [tget_pkg::GROUP_W-1:0]   group_ff, group_in;
   logic                           pinned_ff, pinned_in;
   tget_pkg::token_type            token_ff, token_in;

   logic is_live;
   logic key_match;

   assign is_live   = (status_ff == tget_pkg::ST_LIVE);
   assign key_match = (key_ff == token_i.req.entry_key);

   always_comb begin
      status_in = status_ff;
      key_in    = key_ff;
      group_in  = group_ff;
      pinned_in = pinned_ff;
      token_in  = token_i;
      if (token_i.valid) begin
         unique case (token_i.req.command)
            tget_pkg::CMD_INSERT: begin
               // claim the first empty slot reached
               if (!token_i.hit && status_ff == tget_pkg::ST_EMPTY) begin
                  status_in    = tget_pkg::ST_LIVE;
                  key_in       = token_i.req.entry_key;
                  group_in     = token_i.req.group_tag;
                  pinned_in    = token_i.req.pinned;
                  token_in.hit = 1'b1;
               end
            end
            tget_pkg::CMD_REMOVE: begin
               if (!token_i.hit && is_live && key_match) begin
                  token_in.hit = 1'b1;
                  status_in    = pinned_ff ? tget_pkg::ST_RETIRED : tget_pkg::ST_EMPTY;
               end
            end
            tget_pkg::CMD_CLEAR: begin
               if (status_ff != tget_pkg::ST_EMPTY && group_ff == token_i.req.group_tag) begin
                  status_in = tget_pkg::ST_EMPTY;
               end
            end
            tget_pkg::CMD_LOOKUP: begin
               if (!token_i.hit && is_live && key_match) begin
                  token_in.hit       = 1'b1;
                  token_in.group_out = group_ff;
               end
            end
            tget_pkg::CMD_QUERY: begin
               token_in.live_seen = token_i.live_seen | is_live;
            end
            default: begin
               // unknown command: pass through untouched
               token_in = token_i;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= tget_pkg::ST_EMPTY;
         token_ff  <= '0;
      end else begin
         status_ff <= status_in;
         token_ff  <= token_in;
      end
      key_ff    <= key_in;
      group_ff  <= group_in;
      pinned_ff <= pinned_in;
   end

   assign token_o = token_ff;

endmodule

// ===== rtl/tagged_group_entry_table_top.sv =====
// Channel   Handshake            Payload
// request   start / busy         req_data  (tget_pkg::req_type)
// response  rsp_valid (strobe)   rsp_data  (tget_pkg::rsp_type)
//
// After acceptance a transaction walks the chain of slot cells one cell per
// cycle, and the response is strobed for one cycle as busy drops. Synchronous
// reset empties every slot at once. The response cannot be stalled; one
// transaction is in flight at a time.
module tagged_group_entry_table_top #(
   parameter int ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tget_pkg::req_type  req_data,
   output logic               rsp_valid,
   output tget_pkg::rsp_type  rsp_data
);

   tget_pkg::token_type chain [ENTRIES+1];
   tget_pkg::token_type head_ff, head_in;
   logic                busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tget_pkg::rsp_type   rsp_ff, rsp_in;
   tget_pkg::token_type tail;
   logic [ENTRIES:0]    stage_valid;

   assign chain[0] = head_ff;
   assign tail     = chain[ENTRIES];

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      tget_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .token_i (chain[i]),
         .token_o (chain[i+1])
      );
   end

   for (genvar i = 0; i <= ENTRIES; i++) begin : g_valid
      assign stage_valid[i] = chain[i].valid;
   end

   always_comb begin
      head_in           = '0;
      head_in.valid     = start && !busy_ff;
      head_in.req       = req_data;
      busy_in           = busy_ff;
      rsp_valid_in      = 1'b0;
      rsp_in            = rsp_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
      end
      if (tail.valid) begin
         busy_in              = 1'b0;
         rsp_valid_in         = 1'b1;
         rsp_in.hit           = tail.hit;
         rsp_in.group_out     = tail.group_out;
         rsp_in.none_live     = (tail.req.command == tget_pkg::CMD_QUERY) && !tail.live_seen;
         rsp_in.table_full    = (tail.req.command == tget_pkg::CMD_INSERT) && !tail.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0(stage_valid))
      else $error("more than one transaction in the chain");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after acceptance");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobed while still busy");

   a_full_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.table_full && rsp_data.hit))
      else $error("insert reported both placed and full");

   a_group_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.group_out != '0) |-> rsp_data.hit)
      else $error("group returned without a hit");

endmodule

// ===== test/tget_checker.sv =====
`timescale 1ns / 100ps

module tget_checker #(
   parameter int ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  tget_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  tget_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                outstanding
);

   logic [tget_pkg::KEY_W-1:0]   slot_key   [ENTRIES];
   logic [tget_pkg::GROUP_W-1:0] slot_group [ENTRIES];
   logic                         slot_pin   [ENTRIES];
   tget_pkg::status_type         slot_state [ENTRIES];

   tget_pkg::rsp_type expected_rsp [$];
   int                mismatches;

   function automatic void empty_slot(int i);
      slot_key[i]   = '0;
      slot_group[i] = '0;
      slot_pin[i]   = 1'b0;
      slot_state[i] = tget_pkg::ST_EMPTY;
   endfunction

   function automatic int first_live(logic [tget_pkg::KEY_W-1:0] k);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_state[i] == tget_pkg::ST_LIVE && slot_key[i] == k) return i;
      return -1;
   endfunction

   // Update the table copy with one transaction and return the response it owes
   function automatic tget_pkg::rsp_type apply_command(tget_pkg::req_type r);
      tget_pkg::rsp_type res;
      int                s;
      res = '0;
      s   = -1;
      unique case (r.command)
         tget_pkg::CMD_INSERT: begin
            for (int i = ENTRIES - 1; i >= 0; i--)
               if (slot_state[i] == tget_pkg::ST_EMPTY) s = i;
            if (s < 0) begin
               res.table_full = 1'b1;
            end else begin
               slot_key[s]   = r.entry_key;
               slot_group[s] = r.group_tag;
               slot_pin[s]   = r.pinned;
               slot_state[s] = tget_pkg::ST_LIVE;
               res.hit       = 1'b1;
            end
         end
         tget_pkg::CMD_REMOVE: begin
            s = first_live(r.entry_key);
            if (s >= 0) begin
               res.hit = 1'b1;
               if (slot_pin[s]) slot_state[s] = tget_pkg::ST_RETIRED;
               else empty_slot(s);
            end
         end
         tget_pkg::CMD_CLEAR: begin
            // retired entries go too
            for (int i = 0; i < ENTRIES; i++)
               if (slot_state[i] != tget_pkg::ST_EMPTY && slot_group[i] == r.group_tag)
                  empty_slot(i);
         end
         tget_pkg::CMD_LOOKUP: begin
            s = first_live(r.entry_key);
            if (s >= 0) begin
               res.hit       = 1'b1;
               res.group_out = slot_group[s];
            end
         end
         tget_pkg::CMD_QUERY: begin
            res.none_live = 1'b1;
            for (int i = 0; i < ENTRIES; i++)
               if (slot_state[i] == tget_pkg::ST_LIVE) res.none_live = 1'b0;
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      tget_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) empty_slot(i);
         expected_rsp.delete();
         mismatches = 0;
      end else begin
         // retire the response before taking a new transaction on the same edge
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $error("response with no transaction outstanding: %p", rsp_data);
               mismatches++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, rsp_data.hit);
                  mismatches++;
               end
               if (rsp_data.group_out !== want.group_out) begin
                  $error("group_out: expected %0h, actual %0h",
                         want.group_out, rsp_data.group_out);
                  mismatches++;
               end
               if (rsp_data.none_live !== want.none_live) begin
                  $error("none_live: expected %0d, actual %0d",
                         want.none_live, rsp_data.none_live);
                  mismatches++;
               end
               if (rsp_data.table_full !== want.table_full) begin
                  $error("table_full: expected %0d, actual %0d",
                         want.table_full, rsp_data.table_full);
                  mismatches++;
               end
            end
         end
         if (start && !busy) expected_rsp.push_back(apply_command(req_data));
      end
      fail_count  <= mismatches;
      outstanding <= expected_rsp.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int ENTRIES      = 16;
   localparam int RANDOM_ITEMS = 800;
   localparam int KEY_W        = tget_pkg::KEY_W;
   localparam int GROUP_W      = tget_pkg::GROUP_W;
   localparam int CMD_W        = tget_pkg::CMD_W;

   localparam logic [KEY_W-1:0]   KEY_MAX   = '1;
   localparam logic [GROUP_W-1:0] GROUP_MAX = '1;

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   tget_pkg::req_type req_data = '0;
   logic              busy;
   logic              rsp_valid;
   tget_pkg::rsp_type rsp_data;
   int                fail_count;
   int                outstanding;
   int                sent_by_cmd [8];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   tagged_group_entry_table_top #(.ENTRIES(ENTRIES)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   tget_checker #(.ENTRIES(ENTRIES)) table_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // small pools so that keys and groups collide often
   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] pool [8];
      pool = '{22'h0, 22'h1, 22'h2, 22'h3, 22'h5, 22'h155555, 22'h2AAAAA, KEY_MAX};
      if ($urandom_range(0, 9) < 8) return pool[3'($urandom_range(0, 7))];
      return KEY_W'($urandom());
   endfunction

   function automatic logic [GROUP_W-1:0] pick_group();
      logic [GROUP_W-1:0] pool [4];
      pool = '{22'h0, 22'h1, 22'h155555, GROUP_MAX};
      if ($urandom_range(0, 9) < 8) return pool[2'($urandom_range(0, 3))];
      return GROUP_W'($urandom());
   endfunction

   // phase 0 fills the table, phase 1 is balanced, phase 2 drains it
   function automatic logic [CMD_W-1:0] pick_cmd(int phase);
      int r;
      int lim_ins;
      int lim_rem;
      int lim_clr;
      int lim_look;
      int lim_query;
      r = $urandom_range(0, 99);
      unique case (phase)
         0: begin
            lim_ins = 55; lim_rem = 68; lim_clr = 71; lim_look = 87; lim_query = 95;
         end
         1: begin
            lim_ins = 35; lim_rem = 55; lim_clr = 62; lim_look = 82; lim_query = 94;
         end
         default: begin
            lim_ins = 15; lim_rem = 50; lim_clr = 62; lim_look = 82; lim_query = 94;
         end
      endcase
      if (r < lim_ins) return tget_pkg::CMD_INSERT;
      if (r < lim_rem) return tget_pkg::CMD_REMOVE;
      if (r < lim_clr) return tget_pkg::CMD_CLEAR;
      if (r < lim_look) return tget_pkg::CMD_LOOKUP;
      if (r < lim_query) return tget_pkg::CMD_QUERY;
      return CMD_W'($urandom_range(tget_pkg::CMD_QUERY + 1, 7));
   endfunction

   // Hold start until the transaction is taken, then idle for a random gap unless no_gaps is set
   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                        input logic [GROUP_W-1:0] g, input logic pin, input bit no_gaps);
      tget_pkg::req_type r;
      int                gap;
      r.command   = cmd;
      r.entry_key = k;
      r.group_tag = g;
      r.pinned    = pin;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sent_by_cmd[cmd]++;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int phase;
      for (int i = 0; i < 8; i++) sent_by_cmd[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, duplicates, pinned retirement, group clears
      issue(tget_pkg::CMD_QUERY,  '0, '0, 1'b0, 1'b0);
      issue(tget_pkg::CMD_LOOKUP, '0, '0, 1'b0, 1'b0);
      issue(tget_pkg::CMD_REMOVE, KEY_MAX, '0, 1'b0, 1'b0);
      issue(tget_pkg::CMD_INSERT, '0, '0, 1'b0, 1'b0);
      issue(tget_pkg::CMD_INSERT, KEY_MAX, GROUP_MAX, 1'b1, 1'b0);
      issue(tget_pkg::CMD_INSERT, '0, 22'h2AAAAA, 1'b1, 1'b0);
      issue(tget_pkg::CMD_LOOKUP, '0, '0, 1'b0, 1'b0);
      issue(tget_pkg::CMD_REMOVE, KEY_MAX, '0, 1'b0, 1'b0);
      issue(tget_pkg::CMD_LOOKUP, KEY_MAX, '0, 1'b0, 1'b0);
      issue(tget_pkg::CMD_REMOVE, KEY_MAX, '0, 1'b0, 1'b0);
      issue(tget_pkg::CMD_QUERY,  '0, '0, 1'b0, 1'b0);
      issue(tget_pkg::CMD_INSERT, 22'h155555, 22'h155555, 1'b0, 1'b0);
      issue(tget_pkg::CMD_REMOVE, '0, '0, 1'b0, 1'b0);
      issue(tget_pkg::CMD_LOOKUP, '0, '0, 1'b0, 1'b0);
      issue(tget_pkg::CMD_REMOVE, '0, '0, 1'b0, 1'b0);
      issue(tget_pkg::CMD_CLEAR,  '0, GROUP_MAX, 1'b0, 1'b0);
      issue(tget_pkg::CMD_CLEAR,  '0, 22'h2AAAAA, 1'b0, 1'b0);
      issue(tget_pkg::CMD_CLEAR,  '0, 22'h155555, 1'b0, 1'b0);
      issue(tget_pkg::CMD_QUERY,  '0, '0, 1'b0, 1'b0);
      for (int u = tget_pkg::CMD_QUERY + 1; u < 8; u++)
         issue(CMD_W'(u), KEY_MAX, GROUP_MAX, 1'b1, 1'b0);
      issue(tget_pkg::CMD_CLEAR,  KEY_MAX, '0, 1'b0, 1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         phase = (n / 100) % 3;
         issue(pick_cmd(phase), pick_key(), pick_group(), 1'($urandom_range(0, 1)),
               (n / 50) % 5 == 4);
      end
      start <= 1'b0;

      @(posedge clock);
      do @(posedge clock); while (outstanding != 0);
      repeat (ENTRIES + 4) @(posedge clock);

      $display("Covered %0d inserts, %0d removes, %0d group clears, %0d lookups,",
               sent_by_cmd[tget_pkg::CMD_INSERT], sent_by_cmd[tget_pkg::CMD_REMOVE],
               sent_by_cmd[tget_pkg::CMD_CLEAR], sent_by_cmd[tget_pkg::CMD_LOOKUP]);
      $display("%0d live queries and %0d unassigned commands, with random idle gaps.",
               sent_by_cmd[tget_pkg::CMD_QUERY],
               sent_by_cmd[tget_pkg::CMD_QUERY + 1] + sent_by_cmd[tget_pkg::CMD_QUERY + 2]
               + sent_by_cmd[7]);
      if (fail_count == 0 && outstanding == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #10_000_000;
      $error("run timed out with %0d responses outstanding", outstanding);
      $display("status: fail");
      $finish;
   end

endmodule
